[rtl/assert_macros.svh]
// Assertion macros shared by the fingerprint classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define UHF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("uhf assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define UHF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("uhf assertion failed");

`endif

[rtl/uhf_pkg.sv]
// Types and constants of the USB HID host fingerprint classifier.
`timescale 1ns / 1ps

package uhf_pkg;

    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int TICK_W   = 32;
    localparam int CLASS_W  = 3;
    localparam int COUNT_W  = 6;
    localparam int THRESH_W = 4;
    localparam int LIMIT_W  = 16;
    localparam int WIDE_CNT_W = 8;
    localparam int SCORE_W  = 4;
    localparam int NUM_FLAGS = 5;

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ANALYZE = 2'd2;

    // Class request detection on the request type byte.
    localparam logic [BYTE_W-1:0] TYPE_MASK      = 8'h60;
    localparam logic [BYTE_W-1:0] TYPE_CLASS_VAL = 8'h20;

    // HID class request codes.
    localparam logic [BYTE_W-1:0] REQ_SET_IDLE     = 8'h0A;
    localparam logic [BYTE_W-1:0] REQ_SET_PROTOCOL = 8'h0B;
    localparam logic [BYTE_W-1:0] REQ_GET_IDLE     = 8'h02;
    localparam logic [BYTE_W-1:0] REQ_SET_REPORT   = 8'h09;
    localparam logic [BYTE_W-1:0] REQ_GET_REPORT   = 8'h01;

    // Bit positions in the seen-request flags.
    localparam int FLAG_SET_IDLE  = 0;
    localparam int FLAG_SET_PROTO = 1;
    localparam int FLAG_GET_IDLE  = 2;
    localparam int FLAG_SET_REP   = 3;
    localparam int FLAG_GET_REP   = 4;

    localparam logic [BYTE_W-1:0] PROTO_RESET  = 8'hFF;
    localparam logic [BYTE_W-1:0] PROTO_BOOT   = 8'h00;
    localparam logic [BYTE_W-1:0] PROTO_REPORT = 8'h01;

    // Host class codes.
    localparam logic [CLASS_W-1:0] HOST_UNKNOWN = 3'd0;
    localparam logic [CLASS_W-1:0] HOST_WIN     = 3'd1;
    localparam logic [CLASS_W-1:0] HOST_MAC     = 3'd2;
    localparam logic [CLASS_W-1:0] HOST_CHROME  = 3'd3;
    localparam logic [CLASS_W-1:0] HOST_LNX     = 3'd4;

    // Configuration registers.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIMIT = 1'b1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd3;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd100;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_RECORD,
        CMD_ANALYZE
    } cmd_kind_t;

    // One decoded item as it waits in the queue.
    typedef struct packed {
        cmd_kind_t              kind;
        logic                   is_class;
        logic [NUM_FLAGS-1:0]   flag_set;
        logic [BYTE_W-1:0]      proto_value;
        logic [TICK_W-1:0]      now_ms;
    } cmd_t;

    // Capture summary latched by an analyze item for scoring.
    typedef struct packed {
        logic                   any_events;
        logic                   idle_set;
        logic                   idle_get;
        logic                   rpt_set;
        logic                   rpt_get;
        logic                   boot;
        logic                   report_proto;
        logic                   fast;
        logic [WIDE_CNT_W-1:0]  class_count;
        logic [COUNT_W-1:0]     events_seen;
        logic [COUNT_W-1:0]     class_seen;
    } snap_t;

endpackage

[rtl/uhf_setup_if.sv]
// Channel that carries setup request items into the classifier.
`timescale 1ns / 1ps

interface uhf_setup_if import uhf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   request_type;
    logic [BYTE_W-1:0]   request_code;
    logic [VALUE_W-1:0]  request_value;
    logic [TICK_W-1:0]   now_ms;

    modport source (
        output valid, mode, request_type, request_code, request_value, now_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, request_type, request_code, request_value, now_ms,
        output ready
    );
endinterface

[rtl/uhf_report_if.sv]
// Channel that carries classification result items out of the classifier.
`timescale 1ns / 1ps

interface uhf_report_if import uhf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CLASS_W-1:0]  host_class;
    logic [COUNT_W-1:0]  events_seen;
    logic [COUNT_W-1:0]  class_requests_seen;

    modport source (
        output valid, host_class, events_seen, class_requests_seen,
        input  ready
    );
    modport sink (
        input  valid, host_class, events_seen, class_requests_seen,
        output ready
    );
endinterface

[rtl/uhf_front.sv]
// Front end: accepts setup items and decodes them into queue commands.
`timescale 1ns / 1ps

module uhf_front import uhf_pkg::*;
(
    uhf_setup_if.sink setup,
    input  logic      q_full,
    output logic      push,
    output cmd_t      push_cmd
);

    logic is_class;

    assign setup.ready = !q_full;

    assign is_class = (setup.request_type & TYPE_MASK) == TYPE_CLASS_VAL;

    always_comb
    begin
        push_cmd.is_class    = is_class;
        push_cmd.flag_set    = '0;
        push_cmd.proto_value = setup.request_value[BYTE_W-1:0];
        push_cmd.now_ms      = setup.now_ms;
        push_cmd.kind        = CMD_START;
        push                 = setup.valid && !q_full;

        case (setup.mode)
            MODE_START:   push_cmd.kind = CMD_START;
            MODE_RECORD:  push_cmd.kind = CMD_RECORD;
            MODE_ANALYZE: push_cmd.kind = CMD_ANALYZE;
            default:      push = 1'b0;   // The unused mode is taken and dropped.
        endcase

        if (is_class)
        begin
            case (setup.request_code)
                REQ_SET_IDLE:     push_cmd.flag_set[FLAG_SET_IDLE]  = 1'b1;
                REQ_SET_PROTOCOL: push_cmd.flag_set[FLAG_SET_PROTO] = 1'b1;
                REQ_GET_IDLE:     push_cmd.flag_set[FLAG_GET_IDLE]  = 1'b1;
                REQ_SET_REPORT:   push_cmd.flag_set[FLAG_SET_REP]   = 1'b1;
                REQ_GET_REPORT:   push_cmd.flag_set[FLAG_GET_REP]   = 1'b1;
                default:          push_cmd.flag_set = '0;
            endcase
        end
    end

endmodule

[rtl/uhf_queue.sv]
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module uhf_queue import uhf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `UHF_ASSERT_ALWAYS(a_count_in_range, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `UHF_ASSERT_ALWAYS(a_no_pop_empty, !pop || count_reg != '0)

endmodule

[rtl/uhf_back.sv]
// Back end: applies queued commands to the capture state and scores hosts.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module uhf_back import uhf_pkg::*;
#(
    parameter int MAX_EVENTS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                pop,
    input  logic [THRESH_W-1:0] threshold,
    input  logic [LIMIT_W-1:0]  fast_limit,
    uhf_report_if.source        report
);

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);

    // Capture state.
    logic                  capturing_reg;
    logic [CNT_W-1:0]      event_total_reg;
    logic [CNT_W-1:0]      class_total_reg;
    logic [NUM_FLAGS-1:0]  seen_flags_reg;
    logic [BYTE_W-1:0]     protocol_reg;
    logic [TICK_W-1:0]     start_tick_reg;
    logic [TICK_W-1:0]     last_elapsed_reg;

    // Snapshot stage and output register.
    logic                  snap_valid_reg;
    snap_t                 snap_reg;
    snap_t                 snap_next;
    logic                  out_valid_reg;
    logic [CLASS_W-1:0]    host_class_reg;
    logic [CLASS_W-1:0]    host_class_next;
    logic [COUNT_W-1:0]    events_seen_reg;
    logic [COUNT_W-1:0]    class_seen_reg;

    logic                  snap_adv;
    logic                  snap_free;
    logic                  do_record;
    logic [WIDE_CNT_W-1:0] event_wide;
    logic [WIDE_CNT_W-1:0] class_wide;
    logic [SCORE_W-1:0]    score_wn;
    logic [SCORE_W-1:0]    score_mc;
    logic [SCORE_W-1:0]    score_lnx;
    logic [SCORE_W-1:0]    score_chr;
    logic [SCORE_W-1:0]    best;
    logic [WIDE_CNT_W-1:0] c;

    assign snap_adv  = snap_valid_reg && (!out_valid_reg || report.ready);
    assign snap_free = !snap_valid_reg || snap_adv;
    assign pop       = q_valid && (q_cmd.kind != CMD_ANALYZE || snap_free);
    assign do_record = pop && q_cmd.kind == CMD_RECORD && capturing_reg
                       && event_total_reg < CNT_W'(MAX_EVENTS);

    assign event_wide = WIDE_CNT_W'(event_total_reg);
    assign class_wide = WIDE_CNT_W'(class_total_reg);

    always_comb
    begin
        snap_next.any_events   = event_total_reg != '0;
        snap_next.idle_set     = seen_flags_reg[FLAG_SET_IDLE];
        snap_next.idle_get     = seen_flags_reg[FLAG_GET_IDLE];
        snap_next.rpt_set      = seen_flags_reg[FLAG_SET_REP];
        snap_next.rpt_get      = seen_flags_reg[FLAG_GET_REP];
        snap_next.boot         = seen_flags_reg[FLAG_SET_PROTO] && protocol_reg == PROTO_BOOT;
        snap_next.report_proto = seen_flags_reg[FLAG_SET_PROTO]
                                 && protocol_reg == PROTO_REPORT;
        snap_next.fast         = last_elapsed_reg != '0
                                 && last_elapsed_reg[TICK_W-1:LIMIT_W] == '0
                                 && last_elapsed_reg[LIMIT_W-1:0] < fast_limit;
        snap_next.class_count  = class_wide;
        snap_next.events_seen  = event_wide[COUNT_W-1:0];
        snap_next.class_seen   = class_wide[COUNT_W-1:0];
    end

    // Scoring of the latched summary.
    always_comb
    begin
        c = snap_reg.class_count;

        score_wn  = (snap_reg.idle_set ? 4'd1 : 4'd0)
                  + (snap_reg.idle_get ? 4'd3 : 4'd0)
                  + (snap_reg.rpt_set  ? 4'd2 : 4'd0)
                  + (snap_reg.rpt_get  ? 4'd1 : 4'd0)
                  + ((c >= 8'd4) ? 4'd2 : 4'd0)
                  + ((c >= 8'd6) ? 4'd1 : 4'd0);

        score_mc  = (snap_reg.idle_set ? 4'd1 : 4'd0)
                  + (snap_reg.boot     ? 4'd3 : 4'd0)
                  + (snap_reg.rpt_get  ? 4'd1 : 4'd0)
                  + (snap_reg.idle_get ? 4'd0 : 4'd1)
                  + ((c >= 8'd2 && c <= 8'd4) ? 4'd2 : 4'd0)
                  + (snap_reg.fast     ? 4'd1 : 4'd0);

        score_lnx = (snap_reg.idle_set     ? 4'd1 : 4'd0)
                  + (snap_reg.idle_get     ? 4'd0 : 4'd1)
                  + (snap_reg.rpt_set      ? 4'd0 : 4'd1)
                  + (snap_reg.rpt_get      ? 4'd0 : 4'd1)
                  + ((c <= 8'd2) ? 4'd3 : 4'd0)
                  + (snap_reg.report_proto ? 4'd2 : 4'd0);

        score_chr = (snap_reg.idle_set ? 4'd1 : 4'd0)
                  + (snap_reg.boot     ? 4'd2 : 4'd0)
                  + (snap_reg.idle_get ? 4'd0 : 4'd1)
                  + ((c >= 8'd2 && c <= 8'd3) ? 4'd2 : 4'd0)
                  + ((c == 8'd3) ? 4'd1 : 4'd0);

        // The first class wins ties against the threshold; the others must beat the best.
        best            = threshold;
        host_class_next = HOST_UNKNOWN;
        if (snap_reg.any_events)
        begin
            if (score_wn >= best)
            begin
                best            = score_wn;
                host_class_next = HOST_WIN;
            end
            if (score_mc > best)
            begin
                best            = score_mc;
                host_class_next = HOST_MAC;
            end
            if (score_chr > best)
            begin
                best            = score_chr;
                host_class_next = HOST_CHROME;
            end
            if (score_lnx > best)
            begin
                host_class_next = HOST_LNX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg    <= 1'b0;
            event_total_reg  <= '0;
            class_total_reg  <= '0;
            seen_flags_reg   <= '0;
            protocol_reg     <= PROTO_RESET;
            start_tick_reg   <= '0;
            last_elapsed_reg <= '0;
            snap_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop && q_cmd.kind == CMD_START)
            begin
                capturing_reg    <= 1'b1;
                event_total_reg  <= '0;
                class_total_reg  <= '0;
                seen_flags_reg   <= '0;
                protocol_reg     <= PROTO_RESET;
                start_tick_reg   <= q_cmd.now_ms;
                last_elapsed_reg <= '0;
            end
            else if (do_record)
            begin
                event_total_reg  <= event_total_reg + 1'b1;
                last_elapsed_reg <= q_cmd.now_ms - start_tick_reg;
                seen_flags_reg   <= seen_flags_reg | q_cmd.flag_set;
                if (q_cmd.is_class)
                begin
                    class_total_reg <= class_total_reg + 1'b1;
                end
                if (q_cmd.flag_set[FLAG_SET_PROTO])
                begin
                    protocol_reg <= q_cmd.proto_value;
                end
            end
            else if (pop && q_cmd.kind == CMD_ANALYZE)
            begin
                capturing_reg <= 1'b0;
            end

            if (pop && q_cmd.kind == CMD_ANALYZE)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_adv)
            begin
                snap_valid_reg <= 1'b0;
            end

            if (snap_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_cmd.kind == CMD_ANALYZE)
        begin
            snap_reg <= snap_next;
        end
        if (snap_adv)
        begin
            host_class_reg  <= host_class_next;
            events_seen_reg <= snap_reg.events_seen;
            class_seen_reg  <= snap_reg.class_seen;
        end
    end

    assign report.valid               = out_valid_reg;
    assign report.host_class          = host_class_reg;
    assign report.events_seen         = events_seen_reg;
    assign report.class_requests_seen = class_seen_reg;

    `UHF_ASSERT_ALWAYS(a_event_limit, event_total_reg <= CNT_W'(MAX_EVENTS))
    `UHF_ASSERT_ALWAYS(a_class_le_events, class_total_reg <= event_total_reg)
    `UHF_ASSERT_NEXT(a_snap_held, snap_valid_reg && !snap_adv, snap_valid_reg)

endmodule

[rtl/usb_hid_host_fingerprint_core.sv]
// Top level of the USB HID host fingerprint classifier.
// Setup items arrive on the setup channel (valid/ready); mode selects start,
// record or analyze. Start opens a capture and latches the tick, record adds
// one setup request while the capture is open and below MAX_EVENTS, and
// analyze closes the capture and sends one item on the report channel with
// the host class and the event and class-request counts.
// Throughput is one setup item per cycle while the queue is not full. The front
// end decodes each item into a four-entry command queue, and the back end retires
// one command per cycle unless an analyze waits for the summary register. An
// analyze item passes through the queue, then the summary register that latches
// the capture summary, then the output register that holds its score.
// When the report receiver stalls, the summary and output registers hold the
// pending results; record and start commands keep retiring behind them, and
// only a further analyze waits, until the queue fills and setup.ready drops.
// Reset clears the capture, empties the queue and loads the threshold with 3
// and the fast enumeration limit with 100 ms. Configuration writes take effect
// at the clock edge at which cfg_we is high and are meant for idle periods.
`timescale 1ns / 1ps

module usb_hid_host_fingerprint_core import uhf_pkg::*;
#(
    parameter int MAX_EVENTS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    uhf_setup_if.sink            setup,
    uhf_report_if.source         report,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    logic [THRESH_W-1:0] threshold_reg;
    logic [LIMIT_W-1:0]  fast_limit_reg;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    // Configuration registers, written through the plain write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESH_RESET;
            fast_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[THRESH_W-1:0];
                CFG_FAST_LIMIT: fast_limit_reg <= cfg_data;
                default:        threshold_reg  <= threshold_reg;
            endcase
        end
    end

    // Front end decodes items and drops the unused mode.
    uhf_front u_front (
        .setup    (setup),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue lets the front keep accepting while the back waits.
    uhf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Back end owns the capture state, the scoring and the report register.
    uhf_back #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .threshold  (threshold_reg),
        .fast_limit (fast_limit_reg),
        .report     (report)
    );

endmodule
